>>> src/sitr_pkg.sv
// Shared constants and types for the signed integer to radix text unit.
// No dependencies; every other file in src imports this package.
package sitr_pkg;

    localparam int MAX_RADIX       = 32;
    localparam int SYM_W           = 8;
    localparam int DIGIT_W         = $clog2(MAX_RADIX);
    localparam int RADIX_W         = 6;
    localparam int DATA_W          = 32;
    localparam int PTR_W           = $clog2(DATA_W);

    localparam int CFG_DATA_W      = 64;
    localparam int CFG_ADDR_W      = 6;
    localparam int CFG_IDX_W       = 3;
    localparam int NUM_SYM_REGS    = 4;

    localparam int STEPS_PER_CYCLE = 8;
    localparam int DIV_CYCLES      = DATA_W / STEPS_PER_CYCLE;
    localparam int DIV_CNT_W       = $clog2(DIV_CYCLES);

    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_AW        = 1;
    localparam int QUEUE_CW        = 2;

    localparam logic [SYM_W-1:0] MINUS_CHAR = 8'h2D;
    localparam logic [SYM_W-1:0] PLUS_CHAR  = 8'h2B;

    // register indexes (byte address / 8)
    localparam logic [CFG_IDX_W-1:0] REG_RADIX            = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_MID_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_MID_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH     = 3'd4;

    typedef logic [MAX_RADIX-1:0][SYM_W-1:0] sym_table_t;

    typedef struct packed {
        logic              neg;
        logic [DATA_W-1:0] mag;
    } job_t;

endpackage

>>> src/sitr_in_if.sv
// Input channel: one signed number per word.
// Depends on sitr_pkg.
interface sitr_in_if
    import sitr_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> src/sitr_out_if.sv
// Output channel: one text character per word, flagged on the last one.
// Depends on sitr_pkg.
interface sitr_out_if
    import sitr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] character;
    logic             final_res;

    modport source (output valid, output character, output final_res, input ready);
    modport sink   (input valid, input character, input final_res, output ready);
endinterface

>>> src/sitr_cfg.sv
// APB register file: radix and alphabet, plus a registered alphabet check.
// Depends on sitr_pkg.
module sitr_cfg
    import sitr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [RADIX_W-1:0]    radix,
    output sym_table_t            symbols,
    output logic                  alpha_ok
);

    logic [RADIX_W-1:0]    radix_reg;
    logic [CFG_DATA_W-1:0] sym_reg [NUM_SYM_REGS];
    logic                  alpha_ok_reg;
    logic                  alpha_ok_next;
    logic [CFG_IDX_W-1:0]  idx;
    logic                  wr;

    assign pready = 1'b1;
    assign idx    = paddr[CFG_ADDR_W-1:3];
    assign wr     = psel & penable & pwrite;

    assign radix    = radix_reg;
    assign symbols  = sym_table_t'({sym_reg[3], sym_reg[2], sym_reg[1], sym_reg[0]});
    assign alpha_ok = alpha_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg    <= '0;
            sym_reg[0]   <= '0;
            sym_reg[1]   <= '0;
            sym_reg[2]   <= '0;
            sym_reg[3]   <= '0;
            alpha_ok_reg <= 1'b0;
        end
        else
        begin
            alpha_ok_reg <= alpha_ok_next;
            if (wr)
            begin
                case (idx)
                    REG_RADIX:            radix_reg  <= pwdata[RADIX_W-1:0];
                    REG_SYMBOLS_LOW:      sym_reg[0] <= pwdata;
                    REG_SYMBOLS_MID_LOW:  sym_reg[1] <= pwdata;
                    REG_SYMBOLS_MID_HIGH: sym_reg[2] <= pwdata;
                    REG_SYMBOLS_HIGH:     sym_reg[3] <= pwdata;
                    default:              ;
                endcase
            end
        end
    end

    always_comb
    begin
        case (idx)
            REG_RADIX:            prdata = {{(CFG_DATA_W-RADIX_W){1'b0}}, radix_reg};
            REG_SYMBOLS_LOW:      prdata = sym_reg[0];
            REG_SYMBOLS_MID_LOW:  prdata = sym_reg[1];
            REG_SYMBOLS_MID_HIGH: prdata = sym_reg[2];
            REG_SYMBOLS_HIGH:     prdata = sym_reg[3];
            default:              prdata = '0;
        endcase
    end

    // Radix must lie in 2..MAX_RADIX; symbols in use must avoid the sign characters and be pairwise distinct
    always_comb
    begin
        alpha_ok_next = (radix_reg >= RADIX_W'(2)) && (radix_reg <= RADIX_W'(MAX_RADIX));
        for (int i = 0; i < MAX_RADIX; i++)
        begin
            if (RADIX_W'(i) < radix_reg)
            begin
                if (symbols[i] == PLUS_CHAR || symbols[i] == MINUS_CHAR)
                    alpha_ok_next = 1'b0;
                for (int j = i + 1; j < MAX_RADIX; j++)
                begin
                    if (RADIX_W'(j) < radix_reg && symbols[i] == symbols[j])
                        alpha_ok_next = 1'b0;
                end
            end
        end
    end

endmodule

>>> src/sitr_front.sv
// Front end: takes a number word into a hold register, drops it when the
// alphabet is bad, else splits sign and magnitude into the job queue.
// Depends on sitr_pkg and sitr_in_if.
module sitr_front
    import sitr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      alpha_ok,
    sitr_in_if.sink   number,
    input  logic      q_full,
    output logic      push,
    output job_t      push_job
);

    logic              hold_valid_reg;
    logic [DATA_W-1:0] hold_value_reg;
    logic              consume;

    assign consume      = hold_valid_reg && (!alpha_ok || !q_full);
    assign push         = hold_valid_reg && alpha_ok && !q_full;
    assign number.ready = !hold_valid_reg || consume;

    assign push_job.neg = hold_value_reg[DATA_W-1];
    assign push_job.mag = hold_value_reg[DATA_W-1] ? (~hold_value_reg + 1'b1) : hold_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (number.ready)
            hold_valid_reg <= number.valid;
    end

    always_ff @(posedge clk)
    begin
        if (number.ready && number.valid)
            hold_value_reg <= number.value;
    end

endmodule

>>> src/sitr_fifo.sv
// Short job queue between front and back end.
// Depends on sitr_pkg.
module sitr_fifo
    import sitr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic job_valid,
    output job_t job
);

    job_t                q_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;

    assign full      = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign job_valid = (count_reg != '0);
    assign job       = q_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_job;
    end

endmodule

>>> src/sitr_back.sv
// Back end: divides the magnitude by the radix digit by digit (8 quotient
// bits a cycle), stacks the remainders, then sends sign and symbols out.
// Depends on sitr_pkg and sitr_out_if.
module sitr_back
    import sitr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [RADIX_W-1:0] radix,
    input  sym_table_t         symbols,
    input  logic               job_valid,
    input  job_t               job,
    output logic               job_pop,
    sitr_out_if.source         text
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]           state_reg;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [PTR_W-1:0]     ptr_reg;
    logic                 sign_pend_reg;
    logic [DATA_W-1:0]    work_reg;
    logic [DIGIT_W-1:0]   rem_reg;
    logic [DIGIT_W-1:0]   digit_mem [DATA_W];
    logic                 out_valid_reg;
    logic [SYM_W-1:0]     char_reg;
    logic                 final_reg;

    logic [DATA_W-1:0]    work_next;
    logic [DIGIT_W-1:0]   rem_next;
    logic [RADIX_W-1:0]   trial;
    logic                 last_step;
    logic                 load_out;
    logic                 emit_load;

    assign job_pop   = (state_reg == ST_IDLE) && job_valid;
    assign last_step = (state_reg == ST_DIV) && (step_reg == DIV_CNT_W'(DIV_CYCLES-1));
    assign load_out  = !out_valid_reg || text.ready;
    assign emit_load = (state_reg == ST_EMIT) && load_out;

    assign text.valid     = out_valid_reg;
    assign text.character = char_reg;
    assign text.final_res = final_reg;

    // Restoring division, one quotient bit per step; quotient shifts in below
    always_comb
    begin
        rem_next  = rem_reg;
        work_next = work_reg;
        trial     = '0;
        for (int s = 0; s < STEPS_PER_CYCLE; s++)
        begin
            trial     = {rem_next, work_next[DATA_W-1]};
            work_next = {work_next[DATA_W-2:0], 1'b0};
            if (trial >= radix)
            begin
                rem_next     = DIGIT_W'(trial - radix);
                work_next[0] = 1'b1;
            end
            else
                rem_next = trial[DIGIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            ptr_reg       <= '0;
            sign_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= (state_reg == ST_EMIT);
            case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        step_reg      <= '0;
                        ptr_reg       <= '0;
                        sign_pend_reg <= job.neg;
                        state_reg     <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (last_step)
                    begin
                        step_reg <= '0;
                        // hold the pointer on the top digit when done
                        if (work_next == '0 || ptr_reg == PTR_W'(DATA_W-1))
                            state_reg <= ST_EMIT;
                        else
                            ptr_reg <= ptr_reg + 1'b1;
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
                ST_EMIT:
                begin
                    if (load_out)
                    begin
                        if (sign_pend_reg)
                            sign_pend_reg <= 1'b0;
                        else if (ptr_reg == '0)
                            state_reg <= ST_IDLE;
                        else
                            ptr_reg <= ptr_reg - 1'b1;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            work_reg <= job.mag;
            rem_reg  <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            work_reg <= work_next;
            rem_reg  <= last_step ? '0 : rem_next;
        end
        if (last_step)
            digit_mem[ptr_reg] <= rem_next;
        if (emit_load)
        begin
            char_reg  <= sign_pend_reg ? MINUS_CHAR : symbols[digit_mem[ptr_reg]];
            final_reg <= !sign_pend_reg && (ptr_reg == '0);
        end
    end

endmodule

>>> src/signed_integer_to_radix_text_unit.sv
// Signed integer to radix text: APB config, front end, job queue, back end.
// The back end's divider works on one number at a time, digit by digit, while the front end and
// the job queue take new numbers; characters then leave one per cycle while the receiver is ready.
// An accepted number passes the front-end hold register and the job queue on its way to the divider.
// Reset clears the configuration and control state; radix 0 marks the alphabet bad, so numbers
// are dropped until a valid alphabet is written. Depends on sitr_pkg, the interfaces, submodules.
module signed_integer_to_radix_text_unit
    import sitr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    sitr_in_if.sink               number,
    sitr_out_if.source            text,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [RADIX_W-1:0] radix;
    sym_table_t         symbols;
    logic               alpha_ok;
    logic               push;
    job_t               push_job;
    logic               q_full;
    logic               pop;
    logic               job_valid;
    job_t               job;

    sitr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .radix    (radix),
        .symbols  (symbols),
        .alpha_ok (alpha_ok)
    );

    sitr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .alpha_ok (alpha_ok),
        .number   (number),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    sitr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .job_valid (job_valid),
        .job       (job)
    );

    sitr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .radix     (radix),
        .symbols   (symbols),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (pop),
        .text      (text)
    );

endmodule

>>> src/sitr_checker.sv
// Port-level checks for the radix text unit, bound to the top level.
// Depends on sitr_pkg.
module sitr_checker
    import sitr_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             text_valid,
    input logic             text_ready,
    input logic [SYM_W-1:0] text_character,
    input logic             text_final_res,
    input logic             pready
);

    // a stalled word holds
    a_text_hold: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_ready |=> text_valid && $stable(text_character)
                                      && $stable(text_final_res))
        else $error("text word changed while stalled");

    // minus is only ever the sign, never the last character
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && text_character == MINUS_CHAR |-> !text_final_res)
        else $error("minus sign flagged as last character");

    // an accepted minus is never followed at once by a second valid minus
    a_no_double_minus: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && text_ready && text_character == MINUS_CHAR
        |=> !(text_valid && text_character == MINUS_CHAR))
        else $error("two sign characters in a row");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind signed_integer_to_radix_text_unit sitr_checker u_sitr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .text_valid     (text.valid),
    .text_ready     (text.ready),
    .text_character (text.character),
    .text_final_res (text.final_res),
    .pready         (pready)
);

>>> tb/sv/tb_signed_integer_to_radix_text_unit.sv
// Testbench for signed_integer_to_radix_text_unit: directed and random numbers under several
// alphabets, each character word checked against a local prediction of the number's text.
// Depends on sitr_pkg, sitr_in_if, sitr_out_if and the unit itself.
module tb_signed_integer_to_radix_text_unit;
    import sitr_pkg::*;

    localparam int HALF_PERIOD    = 2;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SHOWN_ERRORS   = 10;
    localparam int SYMS_BITS      = MAX_RADIX * SYM_W;
    localparam int ITEMS_PER_MODE = 52;

    typedef struct packed {
        logic [SYM_W-1:0] character;
        logic             final_res;
    } text_char_t;

    typedef enum int {
        BAD_RADIX_LOW,
        BAD_RADIX_HIGH,
        BAD_PLUS,
        BAD_MINUS,
        BAD_REPEAT
    } alphabet_flaw_e;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    sitr_in_if  number_ch();
    sitr_out_if text_ch();

    signed_integer_to_radix_text_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .number  (number_ch),
        .text    (text_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // local copy of the configuration registers
    logic [RADIX_W-1:0]   cfg_radix   = '0;
    logic [SYMS_BITS-1:0] cfg_symbols = '0;

    text_char_t pending_chars [$];
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         error_count    = 0;
    int         quiet_cycles   = 0;

    always #(HALF_PERIOD) clk = ~clk;

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= SHOWN_ERRORS)
            $display("mismatch: %s", msg);
    endfunction

    function automatic logic [SYM_W-1:0] symbol_of(input int idx);
        return cfg_symbols[idx*SYM_W +: SYM_W];
    endfunction

    function automatic bit alphabet_ok();
        int n;
        n = cfg_radix;
        if (n < 2 || n > MAX_RADIX)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (symbol_of(i) == PLUS_CHAR || symbol_of(i) == MINUS_CHAR)
                return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (symbol_of(i) == symbol_of(j))
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Queue the characters that one number turns into, most significant digit first.
    function automatic void predict_text(input logic signed [DATA_W-1:0] v);
        logic [DATA_W-1:0] mag;
        logic [DATA_W-1:0] base;
        logic [SYM_W-1:0]  digits [DATA_W];
        text_char_t        c;
        int                nd;
        if (!alphabet_ok())
            return;
        mag = v;
        if (v[DATA_W-1])
            mag = -mag;
        base = cfg_radix;
        nd = 0;
        do
        begin
            digits[nd] = symbol_of(int'(mag % base));
            mag = mag / base;
            nd++;
        end
        while (mag != 0 && nd < DATA_W);
        if (v[DATA_W-1])
        begin
            c.character = MINUS_CHAR;
            c.final_res = 1'b0;
            pending_chars.push_back(c);
        end
        for (int k = nd - 1; k >= 0; k--)
        begin
            c.character = digits[k];
            c.final_res = (k == 0);
            pending_chars.push_back(c);
        end
    endfunction

    function automatic sym_table_t text_table(input string s);
        sym_table_t t;
        t = '0;
        for (int i = 0; i < s.len() && i < MAX_RADIX; i++)
            t[i] = s[i];
        return t;
    endfunction

    // Distinct legal symbols below n; bytes from n up hold junk, signs and repeats included.
    function automatic sym_table_t random_alphabet(input int n);
        sym_table_t       t;
        bit               taken [256];
        logic [SYM_W-1:0] b;
        taken = '{default: 1'b0};
        for (int i = 0; i < MAX_RADIX; i++)
        begin
            if (i < n)
            begin
                do
                    b = $urandom_range(255);
                while (taken[b] || b == PLUS_CHAR || b == MINUS_CHAR);
                taken[b] = 1'b1;
                t[i] = b;
            end
            else
            begin
                case ($urandom_range(3))
                    0: t[i] = MINUS_CHAR;
                    1: t[i] = PLUS_CHAR;
                    2: t[i] = t[0];
                    default: t[i] = $urandom_range(255);
                endcase
            end
        end
        return t;
    endfunction

    function automatic void spoil_alphabet(inout logic [RADIX_W-1:0] r, inout sym_table_t t);
        int             i;
        int             j;
        alphabet_flaw_e flaw;
        flaw = alphabet_flaw_e'($urandom_range(int'(BAD_REPEAT)));
        i = $urandom_range(r - 1);
        case (flaw)
            BAD_RADIX_LOW:  r = $urandom_range(1);
            BAD_RADIX_HIGH: r = $urandom_range((1 << RADIX_W) - 1, MAX_RADIX + 1);
            BAD_PLUS:       t[i] = PLUS_CHAR;
            BAD_MINUS:      t[i] = MINUS_CHAR;
            BAD_REPEAT:
            begin
                j = (i + 1 + $urandom_range(r - 2)) % r;
                t[j] = t[i];
            end
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] random_value();
        case ($urandom_range(4))
            0: return $urandom_range(40) - 20;
            1: return {1'b1, {(DATA_W-1){1'b0}}} + $urandom_range(40);
            2: return {1'b0, {(DATA_W-1){1'b1}}} - $urandom_range(40);
            3: return $urandom >> $urandom_range(DATA_W - 1);
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx * 8);
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_RADIX)
            cfg_radix = data[RADIX_W-1:0];
        else if (idx <= REG_SYMBOLS_HIGH)
            cfg_symbols[int'(idx - REG_SYMBOLS_LOW)*CFG_DATA_W +: CFG_DATA_W] = data;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input logic [CFG_IDX_W-1:0] idx);
        logic [CFG_DATA_W-1:0] want;
        if (idx == REG_RADIX)
            want = CFG_DATA_W'(cfg_radix);
        else
            want = cfg_symbols[int'(idx - REG_SYMBOLS_LOW)*CFG_DATA_W +: CFG_DATA_W];
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CFG_ADDR_W'(idx * 8);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
            flag_error($sformatf("register %0d: want %h got %h", idx, want, prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_alphabet(input logic [RADIX_W-1:0] r, input sym_table_t t);
        logic [SYMS_BITS-1:0] flat;
        flat = t;
        for (int k = 0; k < NUM_SYM_REGS; k++)
            write_reg(CFG_IDX_W'(int'(REG_SYMBOLS_LOW) + k),
                      flat[k*CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_RADIX, CFG_DATA_W'(r));
    endtask

    // Hold valid across back-to-back words; drop it only for idle cycles.
    task automatic send_number(input logic signed [DATA_W-1:0] v);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            number_ch.valid <= 1'b0;
            @(negedge clk);
        end
        number_ch.valid <= 1'b1;
        number_ch.value <= v;
        @(posedge clk);
        while (!number_ch.ready)
            @(posedge clk);
        predict_text(v);
    endtask

    task automatic settle_unit();
        @(negedge clk);
        number_ch.valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic test_reset_state();
        for (int k = REG_RADIX; k <= REG_SYMBOLS_HIGH; k++)
            check_reg(CFG_IDX_W'(k));
        // radix 0 after reset: both numbers are dropped
        send_number(0);
        send_number(-7);
        settle_unit();
    endtask

    task automatic test_register_access();
        for (int k = REG_RADIX; k <= REG_SYMBOLS_HIGH; k++)
            write_reg(CFG_IDX_W'(k), {$urandom, $urandom});
        for (int k = REG_RADIX; k <= REG_SYMBOLS_HIGH; k++)
            check_reg(CFG_IDX_W'(k));
        // writes past the last register must leave everything alone
        for (int k = REG_SYMBOLS_HIGH + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), {$urandom, $urandom});
        for (int k = REG_RADIX; k <= REG_SYMBOLS_HIGH; k++)
            check_reg(CFG_IDX_W'(k));
    endtask

    task automatic test_decimal_extremes();
        program_alphabet(10, text_table("0123456789"));
        send_number(0);
        send_number(1);
        send_number(-1);
        send_number(9);
        send_number(10);
        send_number(-10);
        send_number({1'b0, {(DATA_W-1){1'b1}}});
        send_number({1'b1, {(DATA_W-1){1'b0}}});
        settle_unit();
    endtask

    task automatic test_radix_extremes();
        sym_table_t t;
        program_alphabet(2, text_table("01"));
        send_number({1'b1, {(DATA_W-1){1'b0}}});
        send_number(-1);
        send_number({1'b0, {(DATA_W-1){1'b1}}});
        settle_unit();
        // full alphabet with a zero byte as symbol 0 and 0xFF as the top symbol
        for (int i = 0; i < MAX_RADIX; i++)
            t[i] = SYM_W'(8'h40 + i);
        t[0] = 8'h00;
        t[MAX_RADIX-1] = 8'hFF;
        program_alphabet(MAX_RADIX, t);
        send_number(0);
        send_number(MAX_RADIX - 1);
        send_number(-MAX_RADIX);
        send_number({1'b1, {(DATA_W-1){1'b0}}});
        settle_unit();
    endtask

    task automatic test_unused_symbols();
        sym_table_t t;
        t = text_table("0123456789");
        for (int i = 10; i < MAX_RADIX; i++)
            t[i] = (i % 3 == 0) ? MINUS_CHAR : (i % 3 == 1) ? PLUS_CHAR : t[0];
        program_alphabet(10, t);
        send_number(-123456789);
        settle_unit();
    endtask

    task automatic test_bad_alphabets();
        sym_table_t t;
        program_alphabet(1, text_table("0"));
        send_number(5);
        settle_unit();
        for (int i = 0; i < MAX_RADIX; i++)
            t[i] = SYM_W'(8'h40 + i);
        program_alphabet(MAX_RADIX + 1, t);
        send_number(5);
        settle_unit();
        program_alphabet((1 << RADIX_W) - 1, t);
        send_number(-5);
        settle_unit();
        program_alphabet(4, text_table("01+3"));
        send_number(7);
        settle_unit();
        program_alphabet(2, text_table("0-"));
        send_number(1);
        settle_unit();
        program_alphabet(4, text_table("abca"));
        send_number(3);
        settle_unit();
    endtask

    task automatic test_random_traffic(input int send_pct, input int stall_pct, input int target);
        int                 sent;
        logic [RADIX_W-1:0] r;
        sym_table_t         t;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < target)
        begin
            case ($urandom_range(4))
                0: r = 2;
                1: r = MAX_RADIX;
                default: r = $urandom_range(MAX_RADIX, 2);
            endcase
            t = random_alphabet(r);
            if ($urandom_range(4) == 0)
                spoil_alphabet(r, t);
            program_alphabet(r, t);
            repeat ($urandom_range(20, 6))
            begin
                send_number(random_value());
                sent++;
            end
            settle_unit();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    always @(negedge clk)
        text_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin : check_text
        text_char_t want;
        if (rst_n && text_ch.valid && text_ch.ready)
        begin
            if (pending_chars.size() == 0)
                flag_error($sformatf("unexpected character %h final %b",
                                     text_ch.character, text_ch.final_res));
            else
            begin
                want = pending_chars.pop_front();
                if (text_ch.character !== want.character)
                    flag_error($sformatf("character: want %h got %h",
                                         want.character, text_ch.character));
                if (text_ch.final_res !== want.final_res)
                    flag_error($sformatf("final_res: want %b got %b",
                                         want.final_res, text_ch.final_res));
            end
        end
    end

    // End the run when no word moves on any port for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((number_ch.valid && number_ch.ready) || (text_ch.valid && text_ch.ready)
                || (psel && penable))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("** signed_integer_to_radix_text_unit: FAILED **");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        number_ch.valid = 1'b0;
        number_ch.value = '0;
        text_ch.ready   = 1'b0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_register_access();
        test_decimal_extremes();
        test_radix_extremes();
        test_unused_symbols();
        test_bad_alphabets();
        test_random_traffic(0, 0, ITEMS_PER_MODE);
        test_random_traffic(88, 0, ITEMS_PER_MODE);
        test_random_traffic(0, 88, ITEMS_PER_MODE);
        test_random_traffic(18, 18, ITEMS_PER_MODE);
        settle_unit();

        if (error_count == 0)
            $display("** signed_integer_to_radix_text_unit: PASSED **");
        else
            $display("** signed_integer_to_radix_text_unit: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
src/sitr_pkg.sv
src/sitr_in_if.sv
src/sitr_out_if.sv
src/sitr_cfg.sv
src/sitr_front.sv
src/sitr_fifo.sv
src/sitr_back.sv
src/signed_integer_to_radix_text_unit.sv
src/sitr_checker.sv
tb/sv/tb_signed_integer_to_radix_text_unit.sv
